@@ hdl/itrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared constants, types and helpers of the radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;

  // long division, a few quotient bits per cycle
  localparam int STEP_BITS = 4;
  localparam int DIV_STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int QW        = DIV_STEPS * STEP_BITS;
  localparam int SC_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // digit store holds at most one digit per value bit
  localparam int ADDR_W = $clog2(VALUE_WIDTH);
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_RESET  = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(36);
  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT  = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_LETTER = CHAR_W'(65);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BASE_LOW  = 2'd1,
    ST_BASE_HIGH = 2'd2
  } status_t;

  // control lines from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic div_init;
    logic div_step;
    logic store;
    logic ptr_set;
    logic ptr_dec;
    logic emit_err;
    logic emit_digit;
  } ctrl_t;

  // datapath flags tested by conditional jumps
  typedef struct packed {
    logic in_valid;
    logic base_ok;
    logic out_block;
    logic step_more;
    logic q_nonzero;
    logic ptr_more;
  } stat_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d >= DIGIT_LIMIT) begin
      return dw - CHAR_W'(DIGIT_LIMIT) + ASCII_LETTER;
    end
    return dw + ASCII_ZERO;
  endfunction

endpackage

@@ hdl/integer_to_radix_digits.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts an unsigned value to ASCII digits in a configurable base 2..36.
// ----------------------------------------------------------------------------
// One value is converted at a time. A microcoded sequencer runs a long
// division of the working quotient by the base, four quotient bits per cycle,
// storing each remainder in a small digit RAM, then reads the digits back
// most significant first. Each digit takes a division-init step, the division
// steps and a store step; each emitted beat takes a read step, an emit step
// and a pointer-decrement step, and an emit waits while the output is blocked.
// A bad base branches from the check step to an error step that emits one beat.
// The next value is taken only when the sequencer is back at its fetch step.
// Write radix only while no conversion is running.
// ----------------------------------------------------------------------------
module integer_to_radix_digits
  import itrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [RADIX_W-1:0]     cfg_wr_data,  // radix
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,      // value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,      // digit_char, zero pad
  output logic                   m_tlast,
  output logic [1:0]             m_tuser       // status
);

  logic [RADIX_W-1:0] radix;
  ctrl_t              ctrl;
  stat_t              stat;
  logic [CHAR_W-1:0]  digit_char;
  status_t            status;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  itrd_seq u_seq (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .ctrl(ctrl)
  );

  itrd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .radix     (radix),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .digit_char(digit_char),
    .last_digit(m_tlast),
    .status    (status)
  );

  assign s_tready = ctrl.in_ready;
  assign m_tdata  = OUT_TDATA_W'(digit_char);
  assign m_tuser  = status;

endmodule

@@ hdl/itrd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/itrd_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_seq
// Microcode sequencer: step counter, control ROM and jump condition select.
// ----------------------------------------------------------------------------
module itrd_seq
  import itrd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  localparam int UPC_W = 4;

  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NO_ACCEPT = 3'd2,
    C_BASE_OK   = 3'd3,
    C_OUT_BLOCK = 3'd4,
    C_STEP_MORE = 3'd5,
    C_Q_NONZERO = 3'd6,
    C_PTR_MORE  = 3'd7
  } cond_t;

  typedef struct packed {
    ctrl_t            ctl;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  localparam logic [UPC_W-1:0] S_FETCH    = UPC_W'(0);
  localparam logic [UPC_W-1:0] S_CHECK    = UPC_W'(1);
  localparam logic [UPC_W-1:0] S_ERR      = UPC_W'(2);
  localparam logic [UPC_W-1:0] S_BACK     = UPC_W'(3);
  localparam logic [UPC_W-1:0] S_DIV_INIT = UPC_W'(4);
  localparam logic [UPC_W-1:0] S_DIV_STEP = UPC_W'(5);
  localparam logic [UPC_W-1:0] S_STORE    = UPC_W'(6);
  localparam logic [UPC_W-1:0] S_PTR_SET  = UPC_W'(7);
  localparam logic [UPC_W-1:0] S_READ     = UPC_W'(8);
  localparam logic [UPC_W-1:0] S_EMIT     = UPC_W'(9);
  localparam logic [UPC_W-1:0] S_NEXT     = UPC_W'(10);
  localparam logic [UPC_W-1:0] S_DONE     = UPC_W'(11);

  function automatic uword_t ucode(input logic [UPC_W-1:0] a);
    uword_t w;
    w = '0;
    w.cond   = C_NEVER;
    w.target = S_FETCH;
    unique case (a)
      S_FETCH: begin
        w.ctl.in_ready = 1'b1;
        w.cond         = C_NO_ACCEPT;
        w.target       = S_FETCH;
      end
      S_CHECK: begin
        w.cond   = C_BASE_OK;
        w.target = S_DIV_INIT;
      end
      S_ERR: begin
        w.ctl.emit_err = 1'b1;
        w.cond         = C_OUT_BLOCK;
        w.target       = S_ERR;
      end
      S_BACK: begin
        w.cond = C_ALWAYS;
      end
      S_DIV_INIT: begin
        w.ctl.div_init = 1'b1;
      end
      S_DIV_STEP: begin
        w.ctl.div_step = 1'b1;
        w.cond         = C_STEP_MORE;
        w.target       = S_DIV_STEP;
      end
      S_STORE: begin
        w.ctl.store = 1'b1;
        w.cond      = C_Q_NONZERO;
        w.target    = S_DIV_INIT;
      end
      S_PTR_SET: begin
        w.ctl.ptr_set = 1'b1;
      end
      S_READ: begin
        w.cond = C_NEVER;
      end
      S_EMIT: begin
        w.ctl.emit_digit = 1'b1;
        w.cond           = C_OUT_BLOCK;
        w.target         = S_EMIT;
      end
      S_NEXT: begin
        w.ctl.ptr_dec = 1'b1;
        w.cond        = C_PTR_MORE;
        w.target      = S_READ;
      end
      S_DONE: begin
        w.cond = C_ALWAYS;
      end
      default: begin
        w.cond = C_ALWAYS;
      end
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  uword_t           uw;
  logic             taken;

  always_comb begin
    uw   = ucode(upc);
    ctrl = uw.ctl;
    case (uw.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_ACCEPT: taken = !stat.in_valid;
      C_BASE_OK:   taken = stat.base_ok;
      C_OUT_BLOCK: taken = stat.out_block;
      C_STEP_MORE: taken = stat.step_more;
      C_Q_NONZERO: taken = stat.q_nonzero;
      C_PTR_MORE:  taken = stat.ptr_more;
      default:     taken = 1'b1;
    endcase
    upc_next = taken ? uw.target : upc + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

`ifndef SYNTH
  a_upc_in_program: assert property (@(posedge clk) disable iff (rst)
    upc <= S_DONE)
    else $error("sequencer left the program");

  a_bad_base_errs: assert property (@(posedge clk) disable iff (rst)
    (upc == S_CHECK && !stat.base_ok) |=> upc == S_ERR)
    else $error("invalid base did not branch to error");
`endif

endmodule

@@ hdl/itrd_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_dp
// Datapath: quotient/remainder divider, digit store, read pointer and
// output register.
// ----------------------------------------------------------------------------
module itrd_dp
  import itrd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_t                   ctrl,
  output stat_t                   stat,
  input  logic [RADIX_W-1:0]      radix,
  input  logic                    in_valid,
  input  logic [IN_TDATA_W-1:0]   in_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [CHAR_W-1:0]       digit_char,
  output logic                    last_digit,
  output status_t                 status
);

  logic [QW-1:0]      q;
  logic [QW-1:0]      q_next;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] rem_next;
  logic [SC_W-1:0]    sc;
  logic [CNT_W-1:0]   cnt;
  logic [ADDR_W-1:0]  ptr;
  logic [DIGIT_W-1:0] rdata;
  logic               accept;
  logic               out_block;
  logic               load_out;

  assign accept    = in_valid && ctrl.in_ready;
  assign out_block = out_valid && !out_ready;
  assign load_out  = (ctrl.emit_err || ctrl.emit_digit) && !out_block;

  // STEP_BITS restoring steps of the long division per cycle
  always_comb begin
    logic [DIGIT_W:0] t;
    logic [DIGIT_W:0] b;
    b        = {1'b0, radix};
    rem_next = rem;
    q_next   = q;
    for (int i = 0; i < STEP_BITS; i++) begin
      t      = {rem_next, q_next[QW-1]};
      q_next = {q_next[QW-2:0], 1'b0};
      if (t >= b) begin
        rem_next  = DIGIT_W'(t - b);
        q_next[0] = 1'b1;
      end else begin
        rem_next = t[DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q   <= '0;
      cnt <= '0;
    end else begin
      if (accept) begin
        q   <= QW'(in_data[VALUE_WIDTH-1:0]);
        cnt <= '0;
      end else if (ctrl.div_step) begin
        q <= q_next;
      end
      if (ctrl.store) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      rem <= '0;
      sc  <= SC_W'(DIV_STEPS - 1);
    end else if (ctrl.div_step) begin
      rem <= rem_next;
      if (sc != '0) begin
        sc <= sc - SC_W'(1);
      end
    end
    if (ctrl.ptr_set) begin
      ptr <= ADDR_W'(cnt - CNT_W'(1));
    end else if (ctrl.ptr_dec && ptr != '0) begin
      ptr <= ptr - ADDR_W'(1);
    end
  end

  // remainders least significant first, read back from the top
  itrd_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_WIDTH)
  ) u_store (
    .clk  (clk),
    .we   (ctrl.store),
    .waddr(cnt[ADDR_W-1:0]),
    .wdata(rem),
    .raddr(ptr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (ctrl.emit_err) begin
        digit_char <= '0;
        last_digit <= 1'b1;
        status     <= (radix < RADIX_MIN) ? ST_BASE_LOW : ST_BASE_HIGH;
      end else begin
        digit_char <= to_ascii(rdata);
        last_digit <= (ptr == '0);
        status     <= ST_OK;
      end
    end
  end

  always_comb begin
    stat.in_valid  = in_valid;
    stat.base_ok   = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
    stat.out_block = out_block;
    stat.step_more = (sc != '0);
    stat.q_nonzero = (q != '0);
    stat.ptr_more  = (ptr != '0);
  end

`ifndef SYNTH
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (digit_char == '0 && last_digit))
    else $error("error beat carries a digit");

  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.store |-> cnt < CNT_W'(VALUE_WIDTH))
    else $error("digit store overflow");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("emitted beat lost");
`endif

endmodule
